// ===== design/dtss_pkg.sv =====
// Shared types, widths and the entropy table function of the split search block.
`default_nettype none
package dtss_pkg;

  localparam int unsigned VALUE_BITS       = 16;
  localparam int unsigned LABEL_BITS       = 8;
  localparam int unsigned CFG_BITS         = 4;
  localparam int unsigned GAIN_BITS        = 16;
  localparam int unsigned OUT_SAMPLE_BITS  = 8;
  localparam int unsigned OUT_ATTR_BITS    = 3;
  localparam int unsigned APB_ADDR_BITS    = 3;
  localparam int unsigned APB_DATA_BITS    = 32;

  localparam int unsigned DEF_MAX_SAMPLES        = 256;
  localparam int unsigned DEF_MAX_ATTRIBUTES     = 8;
  localparam int unsigned DEF_TABLE_ADDRESS_BITS = 10;

  // register index, taken from paddr[2]
  localparam logic REG_ATTRIBUTE_COUNT = 1'b0;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] value;
    logic [LABEL_BITS-1:0]        class_label;
    logic                         last_in_set;
  } in_item_t;

  typedef struct packed {
    logic [OUT_SAMPLE_BITS-1:0]   best_sample;
    logic [OUT_ATTR_BITS-1:0]     best_attribute;
    logic signed [VALUE_BITS-1:0] threshold;
    logic signed [GAIN_BITS-1:0]  best_gain;
    logic                         gain_positive;
    logic                         overflow;
  } out_item_t;

  // -p*log2(p) for p = k/2^tb, Q0.16; log2 fraction by repeated squaring
  function automatic logic [15:0] entropy_entry(int unsigned k, int unsigned tb);
    int unsigned n;
    int unsigned frac;
    logic [63:0] y;
    logic [63:0] lval;
    logic [63:0] term;
    if (k == 0) begin
      return 16'h0000;
    end
    n = 0;
    for (int b = 0; b < 32; b++) begin
      if ((k >> b) != 0) n = b;
    end
    y = 64'(k) << (30 - n);
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      frac = frac << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        frac = frac | 1;
      end
    end
    lval = (64'(tb - n) << 16) - 64'(frac);
    term = (64'(k) * lval + (64'd1 << (tb - 1))) >> tb;
    return (term > 64'hFFFF) ? 16'hFFFF : term[15:0];
  endfunction

endpackage
`default_nettype wire

// ===== design/decision_tree_split_search_top.sv =====
// Split search for one ID3 tree node: data set store, gain sequencer and APB register.
//
//   channel | direction | handshake             | payload
//   in      | sink      | in_valid_i/in_stall_o | in_item_i  (value, class_label, last_in_set)
//   out     | source    | out_valid_o/out_stall_i | out_item_o (best split)
//   apb     | slave     | psel/penable/pready   | attribute_count at offset 0
//
// Loading takes one value per cycle into the value memory while no search is running.
// After the item marked last, the search runs once per candidate (sample, attribute):
//   per candidate one sweep of the value and label memories and up to six serial divisions
//   (an empty lower side skips two). An empty set goes straight to the result.
// in_stall_o is high for the whole search; a result waiting on out_stall_i holds the
// sequencer but not loading of the next set. Reset clears the counters, not the memories.
`default_nettype none
module decision_tree_split_search_top #(
  parameter int unsigned MAX_SAMPLES        = dtss_pkg::DEF_MAX_SAMPLES,
  parameter int unsigned MAX_ATTRIBUTES     = dtss_pkg::DEF_MAX_ATTRIBUTES,
  parameter int unsigned TABLE_ADDRESS_BITS = dtss_pkg::DEF_TABLE_ADDRESS_BITS
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  wire dtss_pkg::in_item_t               in_item_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output dtss_pkg::out_item_t                   out_item_o,
  input  wire                                   psel,
  input  wire                                   penable,
  input  wire                                   pwrite,
  input  wire [dtss_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  wire [dtss_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [dtss_pkg::APB_DATA_BITS-1:0]    prdata,
  output logic                                  pready
);
  import dtss_pkg::*;

  localparam int unsigned SW     = $clog2(MAX_SAMPLES);
  localparam int unsigned CW     = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned AW     = (MAX_ATTRIBUTES > 1) ? $clog2(MAX_ATTRIBUTES) : 1;
  localparam int unsigned PW     = $clog2(MAX_ATTRIBUTES + 1);
  localparam int unsigned VDEPTH = MAX_SAMPLES << AW;
  localparam int unsigned TAB    = 1 << TABLE_ADDRESS_BITS;
  localparam int unsigned NW     = CW + 17;
  localparam int unsigned DCW    = $clog2(NW + 1);
  localparam int unsigned HW     = 17;
  localparam int unsigned GW     = 20;
  localparam int unsigned PRW    = 2 * HW;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SETSW = 4'd1;
  localparam logic [3:0] ST_THR   = 4'd2;
  localparam logic [3:0] ST_THRW  = 4'd3;
  localparam logic [3:0] ST_SWEEP = 4'd4;
  localparam logic [3:0] ST_OP    = 4'd5;
  localparam logic [3:0] ST_DIV   = 4'd6;
  localparam logic [3:0] ST_TERM  = 4'd7;
  localparam logic [3:0] ST_TACC  = 4'd8;
  localparam logic [3:0] ST_MUL   = 4'd9;
  localparam logic [3:0] ST_MACC  = 4'd10;
  localparam logic [3:0] ST_CMP   = 4'd11;
  localparam logic [3:0] ST_DONE  = 4'd12;

  // ---------------- configuration
  logic [CFG_BITS-1:0] cfg_q;
  logic [PW-1:0]       ac;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_ATTRIBUTE_COUNT) ? APB_DATA_BITS'(cfg_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_BITS'(1);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_ATTRIBUTE_COUNT) begin
      cfg_q <= pwdata[CFG_BITS-1:0];
    end
  end

  always_comb begin
    if (cfg_q == '0) begin
      ac = PW'(1);
    end else if (32'(cfg_q) > MAX_ATTRIBUTES) begin
      ac = PW'(MAX_ATTRIBUTES);
    end else begin
      ac = PW'(cfg_q);
    end
  end

  // ---------------- memories and entropy table
  logic signed [VALUE_BITS-1:0] vmem [VDEPTH];
  logic [LABEL_BITS-1:0]        lmem [MAX_SAMPLES];
  logic [15:0]                  rom_w [TAB];
  logic signed [VALUE_BITS-1:0] vrd_q;
  logic [LABEL_BITS-1:0]        lrd_q;
  logic [15:0]                  rom_q;
  logic [SW+AW-1:0]             vwaddr, vraddr;
  logic [SW-1:0]                lwaddr, lraddr;
  logic                         vwe, lwe;
  logic [TABLE_ADDRESS_BITS-1:0] rom_addr;

  for (genvar k = 0; k < TAB; k++) begin : g_rom
    assign rom_w[k] = entropy_entry(k, TABLE_ADDRESS_BITS);
  end

  always_ff @(posedge clk_i) begin
    if (vwe) vmem[vwaddr] <= in_item_i.value;
    if (lwe) lmem[lwaddr] <= in_item_i.class_label;
    vrd_q <= vmem[vraddr];
    lrd_q <= lmem[lraddr];
    rom_q <= rom_w[rom_addr];
  end

  // ---------------- loading
  logic [3:0]    state_q;
  logic [CW-1:0] cnt_q;
  logic [PW-1:0] pos_q;
  logic          ovf_q;
  logic          in_acc;
  logic          store_ok;
  logic          pos_wrap;
  logic [CW-1:0] cnt_new;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign store_ok   = (32'(cnt_q) < MAX_SAMPLES);
  assign pos_wrap   = ((pos_q + PW'(1)) >= ac);
  assign cnt_new    = (pos_wrap && store_ok) ? cnt_q + CW'(1) : cnt_q;
  assign vwe        = in_acc && store_ok && (32'(pos_q) < MAX_ATTRIBUTES);
  assign lwe        = in_acc && store_ok && (pos_q == '0);
  assign vwaddr     = {cnt_q[SW-1:0], pos_q[AW-1:0]};
  assign lwaddr     = cnt_q[SW-1:0];

  // ---------------- search datapath
  logic [CW-1:0]  n_q, yes_q, j_q, ya_q, na_q, yb_q, nb_q, tot_q;
  logic           rv_q, set_ph_q, big_q;
  logic [SW-1:0]  ci_q;
  logic [AW-1:0]  ca_q;
  logic [2:0]     opc_q;
  logic [NW-1:0]  num_q;
  logic [CW:0]    rem_q;
  logic [DCW-1:0] dcnt_q;
  logic [HW-1:0]  hacc_q, hset_q;
  logic signed [GW-1:0] gacc_q;
  logic [PRW-1:0] prod_q;
  logic signed [VALUE_BITS-1:0] thr_q, thr0_q;
  logic [LABEL_BITS-1:0] yl_q, label0_q;
  logic [SW-1:0]  bs_q, fs_q;
  logic [AW-1:0]  ba_q, fa_q;
  logic signed [VALUE_BITS-1:0] bt_q, ft_q;
  logic signed [GAIN_BITS-1:0]  bg_q, fg_q;
  logic           hb_q, hf_q, ovf_res_q;
  logic           out_v_q;
  out_item_t      out_q;

  logic [CW-1:0]  op_cnt, op_tot, ta, tb;
  logic [CW+1:0]  r2;
  logic           ge;
  logic [16:0]    p;
  logic [17:0]    idx;
  logic signed [GW-1:0] gq;
  logic signed [GAIN_BITS-1:0] q;
  logic           frac_op;
  logic           up, same;

  assign ta = ya_q + na_q;
  assign tb = yb_q + nb_q;

  always_comb begin
    op_cnt = '0;
    op_tot = n_q;
    case (opc_q)
      3'd0: begin
        op_cnt = set_ph_q ? yes_q : ya_q;
        op_tot = set_ph_q ? n_q : ta;
      end
      3'd1: begin
        op_cnt = set_ph_q ? (n_q - yes_q) : na_q;
        op_tot = set_ph_q ? n_q : ta;
      end
      3'd2: begin
        op_cnt = ta;
        op_tot = n_q;
      end
      3'd3: begin
        op_cnt = yb_q;
        op_tot = tb;
      end
      3'd4: begin
        op_cnt = nb_q;
        op_tot = tb;
      end
      3'd5: begin
        op_cnt = tb;
        op_tot = n_q;
      end
      default: begin
        op_cnt = '0;
        op_tot = n_q;
      end
    endcase
  end

  assign frac_op = !set_ph_q && (opc_q == 3'd2 || opc_q == 3'd5);

  // restoring division, one quotient bit a cycle
  assign r2  = {rem_q, num_q[NW-1]};
  assign ge  = (r2 >= (CW+2)'(tot_q));
  assign p   = num_q[16:0];
  assign idx = (18'(p) + 18'(1 << (15 - TABLE_ADDRESS_BITS))) >> (16 - TABLE_ADDRESS_BITS);
  assign rom_addr = idx[TABLE_ADDRESS_BITS-1:0];

  // Q0.16 gain to Q2.14, floor after adding 2, then saturate
  assign gq = (gacc_q + GW'(2)) >>> 2;
  always_comb begin
    if (gq > GW'(32767)) begin
      q = 16'sh7FFF;
    end else if (gq < -GW'(32768)) begin
      q = -16'sh8000;
    end else begin
      q = gq[GAIN_BITS-1:0];
    end
  end

  assign up   = (vrd_q >= thr_q);
  assign same = (lrd_q == yl_q);

  always_comb begin
    vraddr = {ci_q, ca_q};
    lraddr = ci_q;
    if (state_q == ST_SWEEP || state_q == ST_SETSW) begin
      vraddr = {j_q[SW-1:0], ca_q};
      lraddr = j_q[SW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      pos_q     <= '0;
      ovf_q     <= 1'b0;
      out_v_q   <= 1'b0;
      n_q       <= '0;
      rv_q      <= 1'b0;
      set_ph_q  <= 1'b0;
      opc_q     <= '0;
      dcnt_q    <= '0;
      hb_q      <= 1'b0;
      hf_q      <= 1'b0;
      ovf_res_q <= 1'b0;
      j_q       <= '0;
      ci_q      <= '0;
      ca_q      <= '0;
    end else begin
      if (out_v_q && !out_stall_i && state_q != ST_DONE) out_v_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (lwe && cnt_q == '0) label0_q <= in_item_i.class_label;
            if (vwe && cnt_q == '0 && pos_q == '0) thr0_q <= in_item_i.value;
            if (in_item_i.last_in_set) begin
              n_q       <= cnt_new;
              ovf_res_q <= ovf_q || !store_ok;
              cnt_q     <= '0;
              pos_q     <= '0;
              ovf_q     <= 1'b0;
              hb_q      <= 1'b0;
              hf_q      <= 1'b0;
              bs_q      <= '0;
              ba_q      <= '0;
              bg_q      <= '0;
              bt_q      <= '0;
              fs_q      <= '0;
              fa_q      <= '0;
              fg_q      <= '0;
              ft_q      <= '0;
              yes_q     <= '0;
              j_q       <= '0;
              ci_q      <= '0;
              ca_q      <= '0;
              rv_q      <= 1'b0;
              state_q   <= (cnt_new == '0) ? ST_DONE : ST_SETSW;
            end else begin
              cnt_q <= cnt_new;
              pos_q <= pos_wrap ? '0 : pos_q + PW'(1);
              if (!store_ok) ovf_q <= 1'b1;
            end
          end
        end
        ST_SETSW: begin
          if (j_q != n_q) begin
            j_q  <= j_q + CW'(1);
            rv_q <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
          if (rv_q && lrd_q == label0_q) yes_q <= yes_q + CW'(1);
          if (j_q == n_q && !rv_q) begin
            set_ph_q <= 1'b1;
            opc_q    <= '0;
            hacc_q   <= '0;
            state_q  <= ST_OP;
          end
        end
        ST_THR: begin
          state_q <= ST_THRW;
        end
        ST_THRW: begin
          thr_q   <= vrd_q;
          yl_q    <= lrd_q;
          ya_q    <= '0;
          na_q    <= '0;
          yb_q    <= '0;
          nb_q    <= '0;
          j_q     <= '0;
          rv_q    <= 1'b0;
          state_q <= ST_SWEEP;
        end
        ST_SWEEP: begin
          if (j_q != n_q) begin
            j_q  <= j_q + CW'(1);
            rv_q <= 1'b1;
          end else begin
            rv_q <= 1'b0;
          end
          if (rv_q) begin
            if (up && same)  ya_q <= ya_q + CW'(1);
            if (up && !same) na_q <= na_q + CW'(1);
            if (!up && same)  yb_q <= yb_q + CW'(1);
            if (!up && !same) nb_q <= nb_q + CW'(1);
          end
          if (j_q == n_q && !rv_q) begin
            opc_q   <= '0;
            hacc_q  <= '0;
            gacc_q  <= GW'(hset_q);
            state_q <= ST_OP;
          end
        end
        ST_OP: begin
          tot_q  <= op_tot;
          rem_q  <= '0;
          dcnt_q <= DCW'(NW);
          if (op_tot == '0) begin
            num_q   <= '0;
            state_q <= frac_op ? ST_MUL : ST_TERM;
          end else begin
            num_q   <= NW'({op_cnt, 16'h0000}) + NW'(op_tot >> 1);
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= ge ? (CW+1)'(r2 - (CW+2)'(tot_q)) : (CW+1)'(r2);
          num_q  <= {num_q[NW-2:0], ge};
          dcnt_q <= dcnt_q - DCW'(1);
          if (dcnt_q == DCW'(1)) state_q <= frac_op ? ST_MUL : ST_TERM;
        end
        ST_TERM: begin
          big_q   <= (idx >= 18'(TAB));
          state_q <= ST_TACC;
        end
        ST_TACC: begin
          if (!big_q) hacc_q <= hacc_q + HW'(rom_q);
          if (set_ph_q && opc_q == 3'd1) begin
            hset_q   <= big_q ? hacc_q : hacc_q + HW'(rom_q);
            set_ph_q <= 1'b0;
            state_q  <= ST_THR;
          end else begin
            opc_q   <= opc_q + 3'd1;
            state_q <= ST_OP;
          end
        end
        ST_MUL: begin
          prod_q  <= PRW'(p) * PRW'(hacc_q);
          state_q <= ST_MACC;
        end
        ST_MACC: begin
          gacc_q <= gacc_q - GW'((prod_q + PRW'(32768)) >> 16);
          hacc_q <= '0;
          if (opc_q == 3'd5) begin
            state_q <= ST_CMP;
          end else begin
            opc_q   <= opc_q + 3'd1;
            state_q <= ST_OP;
          end
        end
        ST_CMP: begin
          if (q > bg_q) begin
            bg_q <= q;
            bs_q <= ci_q;
            ba_q <= ca_q;
            bt_q <= thr_q;
            hb_q <= 1'b1;
          end
          if (q < 0 && (!hf_q || q > fg_q)) begin
            fg_q <= q;
            fs_q <= ci_q;
            fa_q <= ca_q;
            ft_q <= thr_q;
            hf_q <= 1'b1;
          end
          if ((PW'(ca_q) + PW'(1)) < ac) begin
            ca_q    <= ca_q + AW'(1);
            state_q <= ST_THR;
          end else begin
            ca_q <= '0;
            if ((CW'(ci_q) + CW'(1)) == n_q) begin
              state_q <= ST_DONE;
            end else begin
              ci_q    <= ci_q + SW'(1);
              state_q <= ST_THR;
            end
          end
        end
        ST_DONE: begin
          if (!out_v_q || !out_stall_i) begin
            out_v_q <= 1'b1;
            out_q.overflow      <= ovf_res_q;
            out_q.gain_positive <= hb_q;
            if (hb_q) begin
              out_q.best_sample    <= OUT_SAMPLE_BITS'(bs_q);
              out_q.best_attribute <= OUT_ATTR_BITS'(ba_q);
              out_q.threshold      <= bt_q;
              out_q.best_gain      <= bg_q;
            end else if (hf_q) begin
              out_q.best_sample    <= OUT_SAMPLE_BITS'(fs_q);
              out_q.best_attribute <= OUT_ATTR_BITS'(fa_q);
              out_q.threshold      <= ft_q;
              out_q.best_gain      <= fg_q;
            end else begin
              out_q.best_sample    <= '0;
              out_q.best_attribute <= '0;
              out_q.threshold      <= (n_q == '0) ? '0 : thr0_q;
              out_q.best_gain      <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ===== design/dtss_checker.sv =====
// Port-level checks for the split search block, bound to its top level.
`default_nettype none
module dtss_checker (
  input wire                      clk_i,
  input wire                      rst_ni,
  input wire                      in_valid_i,
  input wire                      in_stall_o,
  input wire dtss_pkg::in_item_t  in_item_i,
  input wire                      out_valid_o,
  input wire                      out_stall_i,
  input wire dtss_pkg::out_item_t out_item_o
);
  import dtss_pkg::*;

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_item_o))
    else $error("stalled result changed");

  a_pos_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.gain_positive |-> out_item_o.best_gain > 0)
    else $error("positive flag with non-positive gain");

  a_fallback_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.gain_positive |-> out_item_o.best_gain <= 0)
    else $error("fallback result with positive gain");

  // input is stalled right after the closing item
  a_search_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_item_i.last_in_set |=> in_stall_o)
    else $error("item taken during search");

endmodule

bind decision_tree_split_search_top dtss_checker u_dtss_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the ID3 split search block: random data sets against a local gain predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import dtss_pkg::*;

  localparam int unsigned SAMPLES = DEF_MAX_SAMPLES;
  localparam int unsigned ATTRS   = DEF_MAX_ATTRIBUTES;
  localparam int unsigned TBITS   = DEF_TABLE_ADDRESS_BITS;
  localparam logic [APB_ADDR_BITS-1:0] ADDR_ATTR_COUNT = APB_ADDR_BITS'(REG_ATTRIBUTE_COUNT) << 2;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata, prdata;
  logic      pready;

  decision_tree_split_search_top u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_item_i(in_item),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_item_o(out_item),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  in_item_t  pending_values[$];
  out_item_t split_expect_q[$];
  int        errors = 0;
  int        values_sent = 0;
  int        sender_idle_pct = 0;
  int        recv_stall_pct = 0;
  logic      hold_go = 1'b0;
  int        hold_left = 0;

  // predictor state
  logic signed [VALUE_BITS-1:0] value_mem[SAMPLES*ATTRS];
  logic [LABEL_BITS-1:0]        label_mem[SAMPLES];
  int unsigned                  n_loaded, attr_pos;
  bit                           ovf_seen;
  logic [CFG_BITS-1:0]          attr_count_reg;
  logic [15:0]                  log_table[1 << TBITS];

  function automatic logic [15:0] neg_plogp(int unsigned k);
    int unsigned msb, fbits;
    longint unsigned y, l, t;
    if (k == 0) return 16'h0;
    msb = 0;
    while (msb < 31 && (k >> (msb + 1)) != 0) msb++;
    y = longint'(k) << (30 - msb);
    fbits = 0;
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      fbits = fbits << 1;
      if (y >= 64'h8000_0000) begin
        y = y >> 1;
        fbits = fbits | 1;
      end
    end
    l = (longint'(TBITS - msb) << 16) - fbits;
    t = (longint'(k) * l + (64'd1 << (TBITS - 1))) >> TBITS;
    return (t > 64'hFFFF) ? 16'hFFFF : t[15:0];
  endfunction

  function automatic longint prob_q16(longint cnt, longint total);
    if (total == 0) return 0;
    return (cnt * 65536 + total / 2) / total;
  endfunction

  function automatic longint lookup_term(longint p);
    longint idx;
    idx = (p + (1 << (15 - TBITS))) >> (16 - TBITS);
    if (idx >= (1 << TBITS)) return 0;
    return longint'(log_table[idx]);
  endfunction

  function automatic longint side_entropy(longint yes, longint no);
    return lookup_term(prob_q16(yes, yes + no)) + lookup_term(prob_q16(no, yes + no));
  endfunction

  function automatic int gain_q214(longint g);
    longint q;
    q = (g + 2) >>> 2;
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return int'(q);
  endfunction

  function automatic int unsigned eff_attrs();
    if (attr_count_reg == 0) return 1;
    if (attr_count_reg > ATTRS) return ATTRS;
    return attr_count_reg;
  endfunction

  // search over the loaded set, as the block does after the last value
  function automatic out_item_t best_split();
    out_item_t r;
    int unsigned ac, n, yes_all, ya, na, yb, nb;
    int unsigned bs, ba, fs, fa;
    int bg, fg, q;
    bit have_best, have_fb, y;
    longint h_set, g;
    logic signed [VALUE_BITS-1:0] thr;
    ac = eff_attrs();
    n = n_loaded;
    bs = 0; ba = 0; fs = 0; fa = 0; bg = 0; fg = 0;
    have_best = 0; have_fb = 0;
    yes_all = 0;
    for (int unsigned i = 0; i < n; i++) if (label_mem[i] == label_mem[0]) yes_all++;
    h_set = side_entropy(yes_all, n - yes_all);
    for (int unsigned i = 0; i < n; i++) begin
      for (int unsigned a = 0; a < ac; a++) begin
        thr = value_mem[i*ATTRS + a];
        ya = 0; na = 0; yb = 0; nb = 0;
        for (int unsigned j = 0; j < n; j++) begin
          y = (label_mem[j] == label_mem[i]);
          if (value_mem[j*ATTRS + a] >= thr) begin
            if (y) ya++; else na++;
          end else begin
            if (y) yb++; else nb++;
          end
        end
        g = h_set;
        g -= (prob_q16(ya + na, n) * side_entropy(ya, na) + 32768) >>> 16;
        g -= (prob_q16(yb + nb, n) * side_entropy(yb, nb) + 32768) >>> 16;
        q = gain_q214(g);
        if (q > bg) begin
          bg = q; bs = i; ba = a; have_best = 1;
        end
        if (q < 0 && (!have_fb || q > fg)) begin
          fg = q; fs = i; fa = a; have_fb = 1;
        end
      end
    end
    if (!have_best) begin
      if (have_fb) begin
        bs = fs; ba = fa; bg = fg;
      end else begin
        bs = 0; ba = 0; bg = 0;
      end
    end
    r.best_sample    = bs[7:0];
    r.best_attribute = ba[2:0];
    r.threshold      = (n == 0) ? '0 : value_mem[bs*ATTRS + ba];
    r.best_gain      = bg[15:0];
    r.gain_positive  = have_best;
    r.overflow       = ovf_seen;
    return r;
  endfunction

  function automatic void absorb_value(in_item_t it);
    if (n_loaded < SAMPLES) begin
      if (attr_pos == 0) label_mem[n_loaded] = it.class_label;
      value_mem[n_loaded*ATTRS + attr_pos] = it.value;
    end else begin
      ovf_seen = 1;
    end
    attr_pos++;
    if (attr_pos >= eff_attrs()) begin
      attr_pos = 0;
      if (n_loaded < SAMPLES) n_loaded++;
    end
    if (it.last_in_set) begin
      split_expect_q = {split_expect_q, best_split()};
      n_loaded = 0;
      attr_pos = 0;
      ovf_seen = 0;
    end
  endfunction

  // sender
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_item  <= '0;
    end else if (!in_valid || !in_stall) begin
      if (pending_values.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_item  <= pending_values.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall, with a long hold-off on request
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_go) hold_left <= 3000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= hold_go || hold_left > 1 || ($urandom_range(99) < recv_stall_pct);
    end
  end

  // predictor feed and result check
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && in_valid && !in_stall) absorb_value(in_item);
    if (rst_n && out_valid && !out_stall) begin
      if (split_expect_q.size() == 0) begin
        $error("unexpected result item %p", out_item);
        errors++;
      end else begin
        e = split_expect_q.pop_front();
        if (out_item.best_sample !== e.best_sample) begin
          $error("best_sample exp %0d got %0d", e.best_sample, out_item.best_sample);
          errors++;
        end
        if (out_item.best_attribute !== e.best_attribute) begin
          $error("best_attribute exp %0d got %0d", e.best_attribute, out_item.best_attribute);
          errors++;
        end
        if (out_item.threshold !== e.threshold) begin
          $error("threshold exp %0d got %0d", e.threshold, out_item.threshold);
          errors++;
        end
        if (out_item.best_gain !== e.best_gain) begin
          $error("best_gain exp %0d got %0d", e.best_gain, out_item.best_gain);
          errors++;
        end
        if (out_item.gain_positive !== e.gain_positive) begin
          $error("gain_positive exp %0d got %0d", e.gain_positive, out_item.gain_positive);
          errors++;
        end
        if (out_item.overflow !== e.overflow) begin
          $error("overflow exp %0d got %0d", e.overflow, out_item.overflow);
          errors++;
        end
      end
    end
  end

  task automatic push_value(int v, int lbl, bit last);
    in_item_t it;
    it.value = v[15:0];
    it.class_label = lbl[7:0];
    it.last_in_set = last;
    pending_values = {pending_values, it};
    values_sent++;
  endtask

  task automatic wait_drained();
    while (pending_values.size() != 0 || in_valid || split_expect_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_attr_count(int unsigned v);
    logic [APB_DATA_BITS-1:0] rd;
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_ATTR_COUNT; pwdata <= APB_DATA_BITS'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    attr_count_reg = v[3:0];
    pwrite <= 1'b0; penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    rd = prdata;
    psel <= 1'b0; penable <= 1'b0;
    if (rd[CFG_BITS-1:0] !== v[3:0]) begin
      $error("attribute_count readback exp %0d got %0d", v[3:0], rd[CFG_BITS-1:0]);
      errors++;
    end
  endtask

  function automatic int rand_value(int span);
    if (span == 0) return int'($urandom_range(16'hFFFF));
    return int'($urandom_range(span)) - span / 2;
  endfunction

  // one data set; a cut-short final sample is left out by the block
  task automatic push_set(int ns, bit cut_short, int vspan, int lspan);
    int ac, lbl, tail;
    ac = eff_attrs();
    tail = (cut_short && ac > 1) ? $urandom_range(1, ac - 1) : 0;
    if (ns == 0 && tail == 0) ns = 1;
    for (int s = 0; s < ns; s++) begin
      lbl = (lspan == 0) ? $urandom_range(255) : $urandom_range(lspan - 1);
      for (int a = 0; a < ac; a++)
        push_value(rand_value(vspan), a == 0 ? lbl : $urandom_range(255),
                   tail == 0 && s == ns - 1 && a == ac - 1);
    end
    for (int a = 0; a < tail; a++)
      push_value(rand_value(vspan), $urandom_range(255), a == tail - 1);
  endtask

  initial begin
    int vspan, lspan;
    in_valid = 1'b0; psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    paddr = '0; pwdata = '0; in_item = '0;
    n_loaded = 0; attr_pos = 0; ovf_seen = 0; attr_count_reg = 4'd1;
    for (int k = 0; k < (1 << TBITS); k++) log_table[k] = neg_plogp(k);
    foreach (value_mem[i]) value_mem[i] = '0;
    foreach (label_mem[i]) label_mem[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed: extremes of value and label, single sample, one class only
    push_value(-32768, 0, 0);
    push_value(32767, 255, 0);
    push_value(0, 0, 0);
    push_value(-1, 255, 1);
    push_value(5, 7, 1);
    wait_drained();
    write_attr_count(0);      // behaves as one attribute
    push_value(3, 9, 0);
    push_value(-3, 9, 0);
    push_value(100, 9, 1);
    wait_drained();
    write_attr_count(15);     // clamps to eight
    push_set(2, 0, 0, 2);
    wait_drained();
    write_attr_count(3);
    push_value(1, 1, 0); push_value(2, 2, 0); push_value(3, 3, 0);
    push_value(4, 4, 0); push_value(5, 5, 0); push_value(6, 6, 0);
    push_value(7, 7, 1);      // partial third sample dropped
    push_value(-7, 1, 1);     // empty set
    wait_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin sender_idle_pct = 7; recv_stall_pct = 7; end
      endcase
      if (phase == 0) begin
        // more samples than the store holds
        write_attr_count(1);
        push_set(SAMPLES + 4, 0, 0, 3);
        wait_drained();
      end
      if (phase == 3) begin
        write_attr_count(2);
        @(posedge clk); hold_go <= 1'b1;
        @(posedge clk); hold_go <= 1'b0;
        for (int s = 0; s < 5; s++) push_set($urandom_range(2, 6), 0, 40, 2);
        wait_drained();
      end
      while (values_sent < 300 * (phase + 1)) begin
        write_attr_count($urandom_range(3) == 0 ? ($urandom_range(1) ? 0 : 15)
                                                : $urandom_range(1, 8));
        for (int s = $urandom_range(1, 4); s > 0; s--) begin
          vspan = $urandom_range(2) == 0 ? 0 : (1 << $urandom_range(1, 10));
          lspan = $urandom_range(4) == 0 ? 0 : $urandom_range(2, 3);
          push_set($urandom_range(9) == 0 ? $urandom_range(13, 24) : $urandom_range(1, 10),
                   $urandom_range(7) == 0, vspan, lspan);
        end
        wait_drained();
      end
    end

    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
`default_nettype wire
